// ----- hdl/kpl_pkg.sv -----
// Shared types, constants and the key decode table of the keypad lock.
// No dependencies; every other file of the block refers to it by scoped names.
package kpl_pkg;

    // default password length in digits
    localparam int CODE_LEN_DEF = 10;

    // queue between decode and execute
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // key names
    localparam logic [3:0] KEY_A     = 4'hA;
    localparam logic [3:0] KEY_B     = 4'hB;
    localparam logic [3:0] KEY_C     = 4'hC;
    localparam logic [3:0] KEY_D     = 4'hD;
    localparam logic [3:0] KEY_STAR  = 4'hE;
    localparam logic [3:0] KEY_HASH  = 4'hF;
    localparam logic [3:0] KEY_NONE  = 4'h0;

    // marker for a slot that holds no digit
    localparam logic [3:0] EMPTY_SLOT = 4'hF;

    // reset value of the attempt limit
    localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd3;
    localparam logic [3:0] WRONG_MAX         = 4'd15;

    // led bit positions
    localparam int LED_RED   = 0;
    localparam int LED_GREEN = 1;
    localparam int LED_BLUE  = 2;
    localparam int LED_ALARM = 3;

    // input command codes
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // classified operation carried from decode to execute
    typedef enum logic [2:0] {
        OP_RESET  = 3'd0,
        OP_RECORD = 3'd1,
        OP_COMMIT = 3'd2,
        OP_GUESS  = 3'd3,
        OP_CHECK  = 3'd4,
        OP_DIGIT  = 3'd5,
        OP_IGNORE = 3'd6
    } op_t;

    // one queued word
    typedef struct packed {
        op_t        op;
        logic [3:0] key;
    } qword_t;

    // row-major encoder position to key name
    localparam logic [3:0] KEY_MAP [16] = '{
        4'h1, 4'h2, 4'h3, 4'hA,
        4'h4, 4'h5, 4'h6, 4'hB,
        4'h7, 4'h8, 4'h9, 4'hC,
        4'hE, 4'h0, 4'hF, 4'hD
    };

endpackage

// ----- hdl/kpl_front.sv -----
// Front end of the keypad lock: takes input words, decodes the key and classifies it.
// Depends on kpl_pkg for the key table, the operation codes and the queue word type.
module kpl_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [3:0]       raw_code,
    input  logic             q_full,
    output logic             q_push,
    output kpl_pkg::qword_t  q_word
);

    logic [3:0] key;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // key decode
    assign key = (cmd == kpl_pkg::CMD_RESET) ? kpl_pkg::KEY_NONE : kpl_pkg::KEY_MAP[raw_code];

    // classify into an operation
    always_comb
    begin
        q_word.key = key;
        if (cmd == kpl_pkg::CMD_RESET)
        begin
            q_word.op = kpl_pkg::OP_RESET;
        end
        else
        begin
            unique case (key)
                kpl_pkg::KEY_A:    q_word.op = kpl_pkg::OP_RECORD;
                kpl_pkg::KEY_B:    q_word.op = kpl_pkg::OP_COMMIT;
                kpl_pkg::KEY_C:    q_word.op = kpl_pkg::OP_GUESS;
                kpl_pkg::KEY_D:    q_word.op = kpl_pkg::OP_CHECK;
                kpl_pkg::KEY_STAR: q_word.op = kpl_pkg::OP_IGNORE;
                kpl_pkg::KEY_HASH: q_word.op = kpl_pkg::OP_IGNORE;
                default:           q_word.op = kpl_pkg::OP_DIGIT;
            endcase
        end
    end

endmodule

// ----- hdl/kpl_queue.sv -----
// Two-entry queue of classified words between the front and back ends.
// Depends on kpl_pkg for the word type and the queue sizes.
module kpl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kpl_pkg::qword_t  push_word,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output kpl_pkg::qword_t  pop_word
);

    kpl_pkg::qword_t                 mem_reg [kpl_pkg::QUEUE_DEPTH];
    logic [kpl_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [kpl_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [kpl_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign full     = (count_reg == kpl_pkg::QCNT_W'(kpl_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_word = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- hdl/kpl_back.sv -----
// Back end of the keypad lock: executes queued operations and holds the result word.
// Depends on kpl_pkg for operation codes, key names and led positions.
module kpl_back #(
    parameter int CODE_LEN = kpl_pkg::CODE_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  kpl_pkg::qword_t  q_word,
    output logic             q_pop,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             red_led,
    output logic             green_led,
    output logic             blue_led,
    output logic             alarm_led,
    output logic             lock_state,
    output logic [3:0]       key_name,
    output logic             key_taken
);

    localparam int CNT_W = $clog2(CODE_LEN + 1);
    localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

    logic [3:0]       stored_reg [CODE_LEN];
    logic [3:0]       stored_next [CODE_LEN];
    logic [3:0]       entry_reg [CODE_LEN];
    logic [3:0]       entry_next [CODE_LEN];
    logic [CNT_W-1:0] slot_reg, slot_next, slot_inc;
    logic [3:0]       wrong_reg, wrong_next;
    logic             rec_reg, rec_next;
    logic             guess_reg, guess_next;
    logic             locked_reg, locked_next;
    logic             alarm_reg, alarm_next;
    logic [3:0]       led_reg, led_next;
    logic [3:0]       limit_reg;
    logic             taken_next;
    logic             match;
    logic             commit;
    logic             out_valid_reg;
    logic [3:0]       out_led_reg;
    logic             out_lock_reg;
    logic [3:0]       out_key_reg;
    logic             out_taken_reg;

    // take a word when the result register is free or being drained
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign slot_inc  = slot_reg + 1'b1;

    // all-slot compare
    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < CODE_LEN; k++)
        begin
            if (stored_reg[k] != entry_reg[k])
            begin
                match = 1'b0;
            end
        end
    end

    // operation execute
    always_comb
    begin
        stored_next = stored_reg;
        entry_next  = entry_reg;
        slot_next   = slot_reg;
        wrong_next  = wrong_reg;
        rec_next    = rec_reg;
        guess_next  = guess_reg;
        locked_next = locked_reg;
        alarm_next  = alarm_reg;
        led_next    = led_reg;
        taken_next  = (q_word.op != kpl_pkg::OP_RESET) && !alarm_reg;
        commit      = 1'b0;
        if (q_word.op == kpl_pkg::OP_RESET)
        begin
            alarm_next  = 1'b0;
            locked_next = 1'b0;
            guess_next  = 1'b0;
            rec_next    = 1'b0;
            wrong_next  = '0;
            slot_next   = '0;
            led_next    = '0;
        end
        else if (!alarm_reg)
        begin
            unique case (q_word.op)
                kpl_pkg::OP_RECORD:
                begin
                    if (!locked_reg)
                    begin
                        for (int k = 0; k < CODE_LEN; k++)
                        begin
                            entry_next[k] = kpl_pkg::EMPTY_SLOT;
                        end
                        rec_next  = 1'b1;
                        slot_next = '0;
                        led_next  = led_reg & (4'd1 << kpl_pkg::LED_ALARM);
                    end
                end
                kpl_pkg::OP_COMMIT:
                begin
                    commit = !locked_reg;
                end
                kpl_pkg::OP_GUESS:
                begin
                    for (int k = 0; k < CODE_LEN; k++)
                    begin
                        entry_next[k] = kpl_pkg::EMPTY_SLOT;
                    end
                    guess_next = 1'b1;
                    slot_next  = '0;
                    led_next   = led_reg & (4'd1 << kpl_pkg::LED_ALARM);
                end
                kpl_pkg::OP_CHECK:
                begin
                    if (guess_reg)
                    begin
                        guess_next  = 1'b0;
                        slot_next   = '0;
                        locked_next = !match;
                        led_next    = led_reg & (4'd1 << kpl_pkg::LED_ALARM);
                        if (!match)
                        begin
                            led_next[kpl_pkg::LED_RED] = 1'b1;
                            if (wrong_reg != kpl_pkg::WRONG_MAX)
                            begin
                                wrong_next = wrong_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            led_next[kpl_pkg::LED_GREEN] = 1'b1;
                            wrong_next = '0;
                        end
                        if (wrong_next >= limit_reg)
                        begin
                            led_next[kpl_pkg::LED_ALARM] = 1'b1;
                            alarm_next = 1'b1;
                        end
                    end
                end
                kpl_pkg::OP_DIGIT:
                begin
                    if ((rec_reg || guess_reg) && (slot_reg < CNT_W'(CODE_LEN)))
                    begin
                        entry_next[slot_reg[IDX_W-1:0]] = q_word.key;
                        slot_next = slot_inc;
                        // last digit of a recording commits it
                        commit = rec_reg && (slot_inc == CNT_W'(CODE_LEN));
                    end
                end
                kpl_pkg::OP_IGNORE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (commit)
        begin
            stored_next = entry_next;
            led_next    = led_reg & (4'd1 << kpl_pkg::LED_ALARM);
            led_next[kpl_pkg::LED_BLUE] = 1'b1;
            rec_next    = 1'b0;
            locked_next = 1'b1;
        end
    end

    // lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CODE_LEN; k++)
            begin
                stored_reg[k] <= '0;
                entry_reg[k]  <= '0;
            end
            slot_reg   <= '0;
            wrong_reg  <= '0;
            rec_reg    <= 1'b0;
            guess_reg  <= 1'b0;
            locked_reg <= 1'b0;
            alarm_reg  <= 1'b0;
            led_reg    <= '0;
        end
        else if (q_pop)
        begin
            stored_reg <= stored_next;
            entry_reg  <= entry_next;
            slot_reg   <= slot_next;
            wrong_reg  <= wrong_next;
            rec_reg    <= rec_next;
            guess_reg  <= guess_next;
            locked_reg <= locked_next;
            alarm_reg  <= alarm_next;
            led_reg    <= led_next;
        end
    end

    // attempt limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= kpl_pkg::ATTEMPT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_led_reg   <= led_next;
            out_lock_reg  <= locked_next;
            out_key_reg   <= q_word.key;
            out_taken_reg <= taken_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_led    = out_led_reg[kpl_pkg::LED_RED];
    assign green_led  = out_led_reg[kpl_pkg::LED_GREEN];
    assign blue_led   = out_led_reg[kpl_pkg::LED_BLUE];
    assign alarm_led  = out_led_reg[kpl_pkg::LED_ALARM];
    assign lock_state = out_lock_reg;
    assign key_name   = out_key_reg;
    assign key_taken  = out_taken_reg;

    // alarm led follows the alarm flag exactly
    a_alarm_led: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg[kpl_pkg::LED_ALARM] == alarm_reg)
        else $error("alarm led out of step with alarm flag");

    // slot index never passes the password length
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= CNT_W'(CODE_LEN))
        else $error("slot index beyond password length");

    // red and green never lit together
    a_led_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(led_reg[kpl_pkg::LED_RED] && led_reg[kpl_pkg::LED_GREEN]))
        else $error("red and green leds both on");

    // a result that waits is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_key_reg)))
        else $error("pending result word lost");

    // an alarm only rises on a guess check
    a_alarm_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(alarm_reg) |-> $past(q_pop && (q_word.op == kpl_pkg::OP_CHECK)))
        else $error("alarm raised outside a guess check");

endmodule

// ----- hdl/keypad_password_lock.sv -----
// Keypad password lock: decodes keypad words, keeps the password and drives the leds.
// Top level; depends on kpl_pkg, kpl_front, kpl_queue and kpl_back.
//
// One input word (a keypad press or a reset-button event) gives one result word.
// A word is decoded and classified in the cycle it is accepted, waits in a
// two-entry queue, and is executed by the back end, whose compare and copy
// over all password slots run in parallel; each word passes the queue and then
// the result register, so the result appears in the cycle after the word leaves
// the queue. The block sustains one word per cycle while results are taken, and
// a stalled result lets up to two more words be accepted before input ready drops.
// The attempt limit is written through the cfg channel, which is always ready.
module keypad_password_lock #(
    parameter int CODE_LEN = kpl_pkg::CODE_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [3:0] raw_code,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       red_led,
    output logic       green_led,
    output logic       blue_led,
    output logic       alarm_led,
    output logic       lock_state,
    output logic [3:0] key_name,
    output logic       key_taken
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    kpl_pkg::qword_t  push_word;
    kpl_pkg::qword_t  pop_word;

    // decode and classify
    kpl_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .raw_code (raw_code),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    // decoupling queue
    kpl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_word  (pop_word)
    );

    // execute and result register
    kpl_back #(
        .CODE_LEN (CODE_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_word     (pop_word),
        .q_pop      (q_pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_led    (red_led),
        .green_led  (green_led),
        .blue_led   (blue_led),
        .alarm_led  (alarm_led),
        .lock_state (lock_state),
        .key_name   (key_name),
        .key_taken  (key_taken)
    );

endmodule
